@@ design/accumulator_cpu_step_macros.svh @@
// ---------------------------------------------------------------------------
// accumulator_cpu_step assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while arst_n is low
// ---------------------------------------------------------------------------
`ifndef ACCUMULATOR_CPU_STEP_MACROS_SVH
`define ACCUMULATOR_CPU_STEP_MACROS_SVH

// same-cycle implication
`define ACS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ACS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/acs_pkg.sv @@
// ---------------------------------------------------------------------------
// acs_pkg
// shared types, codes and helpers of the accumulator cpu step block
// ---------------------------------------------------------------------------
package acs_pkg;

	localparam int MEM_WORDS = 256;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int REG_COUNT = 4;
	localparam int REG_AW    = 2;
	localparam int DATA_W    = 16;
	localparam int ADDR_W    = 8;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_EXEC  = 2'd1,
		MODE_SETPC = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		OP_LOAD  = 4'd0,
		OP_STORE = 4'd1,
		OP_ADD   = 4'd2,
		OP_SUB   = 4'd3,
		OP_ADDR  = 4'd4,
		OP_SUBR  = 4'd5,
		OP_AND   = 4'd6,
		OP_OR    = 4'd7,
		OP_NOT   = 4'd8,
		OP_JMP   = 4'd9,
		OP_JZ    = 4'd10,
		OP_JP    = 4'd11,
		OP_JN    = 4'd12,
		OP_CMP   = 4'd13,
		OP_CLR   = 4'd14,
		OP_HALT  = 4'd15
	} op_t;

	localparam logic [1:0] CC_NONE = 2'd0;
	localparam logic [1:0] CC_POS  = 2'd1;
	localparam logic [1:0] CC_ZERO = 2'd2;
	localparam logic [1:0] CC_NEG  = 2'd3;

	typedef struct packed {
		mode_t               mode;
		logic [ADDR_W-1:0]   mem_address;
		logic [DATA_W-1:0]   mem_data;
	} item_t;

	// first member is the top bits, so read_data lands lowest
	typedef struct packed {
		logic [ADDR_W-1:0]        store_address;
		logic                     mem_written;
		logic signed [DATA_W-1:0] reg_value;
		logic [REG_AW-1:0]        reg_index;
		logic                     reg_written;
		logic                     halted;
		logic [1:0]               cond_code;
		logic [ADDR_W-1:0]        pc_now;
		logic [DATA_W-1:0]        read_data;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [MEM_AW-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [MEM_AW-1:0] raddr;
	} ram_req_t;

	function automatic logic [1:0] cond_of(input logic [DATA_W-1:0] v);
		logic [1:0] c;
		if (v == '0)
			c = CC_ZERO;
		else if (v[DATA_W-1])
			c = CC_NEG;
		else
			c = CC_POS;
		return c;
	endfunction

endpackage

@@ design/acs_ram.sv @@
// ---------------------------------------------------------------------------
// acs_ram
// simple dual-port synchronous ram, one write and one registered read port
// ---------------------------------------------------------------------------
module acs_ram #(
	parameter int WORDS = 256,
	parameter int WIDTH = 16,
	localparam int AW   = $clog2(WORDS)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

@@ design/acs_core.sv @@
// ---------------------------------------------------------------------------
// acs_core
// sequencer, architectural registers and execute logic of the machine
// ---------------------------------------------------------------------------
`include "accumulator_cpu_step_macros.svh"

module acs_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  acs_pkg::item_t                item,
	input  logic                          can_out,
	output logic                          take,
	output logic                          res_valid,
	output acs_pkg::res_t                 res,
	output acs_pkg::ram_req_t             ram_req,
	input  logic [acs_pkg::DATA_W-1:0]    ram_rdata
);
	import acs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_DEC,
		ST_EXE
	} state_t;

	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   pc_q, pc_d;
	logic [DATA_W-1:0]   ir_q, ir_d;
	logic [1:0]          cc_q, cc_d;
	logic                halt_q, halt_d;
	logic [DATA_W-1:0]   regs_q [REG_COUNT];
	logic                reg_we;
	logic [REG_AW-1:0]   reg_wi;
	logic [DATA_W-1:0]   reg_wv;

	// execute datapath, from the latched instruction
	op_t                 op;
	logic                imm;
	logic [REG_AW-1:0]   r;
	logic [ADDR_W-1:0]   addr;
	logic [DATA_W-1:0]   operand, acc, rr;
	logic [DATA_W-1:0]   x_res;
	logic                x_rw, x_mw, x_halt;
	logic [REG_AW-1:0]   x_idx;
	logic [1:0]          x_cc;
	logic [ADDR_W-1:0]   x_pc;

	always_comb begin
		op      = op_t'(ir_q[15:12]);
		imm     = ir_q[11];
		r       = ir_q[8 +: REG_AW];
		addr    = ir_q[ADDR_W-1:0];
		operand = imm ? {{(DATA_W-ADDR_W){1'b0}}, addr} : ram_rdata;
		acc     = regs_q[0];
		rr      = regs_q[r];
		x_res   = '0;
		x_rw    = 1'b0;
		x_mw    = 1'b0;
		x_idx   = r;
		x_cc    = cc_q;
		x_pc    = pc_q;
		x_halt  = halt_q;
		case (op)
			OP_LOAD:  begin x_res = operand;       x_rw = 1'b1; end
			OP_STORE: begin x_mw = 1'b1;           x_cc = cond_of(rr); end
			OP_ADD:   begin x_res = acc + operand; x_rw = 1'b1; end
			OP_SUB:   begin x_res = acc - operand; x_rw = 1'b1; end
			OP_ADDR:  begin x_res = acc + rr;      x_rw = 1'b1; x_idx = '0; end
			OP_SUBR:  begin x_res = acc - rr;      x_rw = 1'b1; x_idx = '0; end
			OP_AND:   begin x_res = acc & operand; x_rw = 1'b1; end
			OP_OR:    begin x_res = acc | operand; x_rw = 1'b1; end
			OP_NOT:   begin x_res = ~rr;           x_rw = 1'b1; end
			OP_JMP:   x_pc = addr;
			OP_JZ:    if (cc_q == CC_ZERO) x_pc = addr;
			OP_JP:    if (cc_q == CC_POS) x_pc = addr;
			OP_JN:    if (cc_q == CC_NEG) x_pc = addr;
			OP_CMP:   x_cc = cond_of(rr);
			OP_CLR:   begin x_res = '0;            x_rw = 1'b1; end
			OP_HALT:  x_halt = 1'b1;
			default:  ;
		endcase
		if (x_rw)
			x_cc = cond_of(x_res);
	end

	// sequencer
	always_comb begin
		take          = 1'b0;
		res_valid     = 1'b0;
		res           = '0;
		res.pc_now    = pc_q;
		res.cond_code = cc_q;
		res.halted    = halt_q;
		ram_req       = '0;
		state_d       = state_q;
		pc_d          = pc_q;
		ir_d          = ir_q;
		cc_d          = cc_q;
		halt_d        = halt_q;
		reg_we        = 1'b0;
		reg_wi        = x_idx;
		reg_wv        = x_res;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					case (item.mode)
						MODE_WRITE: begin
							if (can_out) begin
								take          = 1'b1;
								res_valid     = 1'b1;
								ram_req.we    = 1'b1;
								ram_req.waddr = item.mem_address[MEM_AW-1:0];
								ram_req.wdata = item.mem_data;
							end
						end
						MODE_SETPC: begin
							if (can_out) begin
								take       = 1'b1;
								res_valid  = 1'b1;
								pc_d       = item.mem_address;
								halt_d     = 1'b0;
								res.pc_now = item.mem_address;
								res.halted = 1'b0;
							end
						end
						MODE_READ: begin
							take          = 1'b1;
							ram_req.re    = 1'b1;
							ram_req.raddr = item.mem_address[MEM_AW-1:0];
							state_d       = ST_RD;
						end
						MODE_EXEC: begin
							if (halt_q) begin
								if (can_out) begin
									take      = 1'b1;
									res_valid = 1'b1;
								end
							end else begin
								take          = 1'b1;
								ram_req.re    = 1'b1;
								ram_req.raddr = pc_q[MEM_AW-1:0];
								state_d       = ST_DEC;
							end
						end
						default: ;
					endcase
				end
			end
			ST_RD: begin
				if (can_out) begin
					res_valid     = 1'b1;
					res.read_data = ram_rdata;
					state_d       = ST_IDLE;
				end
			end
			ST_DEC: begin
				ir_d          = ram_rdata;
				pc_d          = pc_q + ADDR_W'(1);
				ram_req.re    = 1'b1;
				ram_req.raddr = ram_rdata[MEM_AW-1:0];
				state_d       = ST_EXE;
			end
			ST_EXE: begin
				if (can_out) begin
					res_valid         = 1'b1;
					res.read_data     = ir_q;
					res.pc_now        = x_pc;
					res.cond_code     = x_cc;
					res.halted        = x_halt;
					res.reg_written   = x_rw;
					res.reg_index     = x_rw ? x_idx : '0;
					res.reg_value     = x_rw ? x_res : '0;
					res.mem_written   = x_mw;
					res.store_address = x_mw ? addr : '0;
					reg_we            = x_rw;
					ram_req.we        = x_mw;
					ram_req.waddr     = addr[MEM_AW-1:0];
					ram_req.wdata     = rr;
					pc_d              = x_pc;
					cc_d              = x_cc;
					halt_d            = x_halt;
					state_d           = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			ir_q    <= '0;
			cc_q    <= CC_NONE;
			halt_q  <= 1'b0;
			regs_q  <= '{default: '0};
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			ir_q    <= ir_d;
			cc_q    <= cc_d;
			halt_q  <= halt_d;
			if (reg_we)
				regs_q[reg_wi] <= reg_wv;
		end
	end

	`ACS_ASSERT_IMP(a_res_needs_slot, res_valid, can_out, "result issued into a full output slot")
	`ACS_ASSERT_IMP(a_take_needs_item, take, item_valid && state_q == ST_IDLE, "item taken while none pending")
	`ACS_ASSERT_NXT(a_fetch_then_decode, state_q == ST_IDLE && state_d == ST_DEC, $past(ram_req.re), "decode without fetch")
	`ACS_ASSERT_IMP(a_halt_from_exec, halt_q && !$past(halt_q), $past(state_q == ST_EXE), "halt set outside execute")
	`ACS_ASSERT_IMP(a_no_ram_clash, ram_req.we, !ram_req.re, "ram read and write in one cycle")

endmodule

@@ design/accumulator_cpu_step.sv @@
// ---------------------------------------------------------------------------
// accumulator_cpu_step
// small 16-bit accumulator machine stepped one command beat at a time
// ---------------------------------------------------------------------------
// Every input beat gives exactly one output beat. Memory writes, set-pc and
// execute while halted end in the idle state, memory reads go through a read
// state, and an executed instruction through fetch from the single-read-port
// main memory, operand read from the same port, then execute and write-back.
// The main memory is a synchronous ram; the engine runs one command at a time,
// so a read never overlaps a write to the same word. A one-beat input buffer
// takes the next command while the engine works, and an output register holds
// the finished result until it is taken, so neither side waits on the other
// beyond that. Memory contents are undefined until written and are never
// cleared; registers, pc, ir, condition code and halt reset to zero.
// ---------------------------------------------------------------------------
module accumulator_cpu_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // mem_address[7:0], mem_data[23:8]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data[15:0], pc_now[23:16], cond_code[25:24], halted[26],
	// reg_written[27], reg_index[29:28], reg_value[45:30], mem_written[46],
	// store_address[54:47], zero fill[55]
	output logic [55:0] m_tdata
);
	import acs_pkg::*;

	// input buffer
	logic                inq_v_q;
	item_t               inq_q;
	// output register
	logic                out_v_q;
	res_t                out_q;

	logic                take, res_valid, can_out;
	res_t                res;
	ram_req_t            ram_req;
	logic [DATA_W-1:0]   ram_rdata;

	// a result may be written when the slot is empty or drains this cycle
	assign can_out  = !out_v_q || m_tready;
	assign s_tready = !inq_v_q || take;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(56 - $bits(res_t)){1'b0}}, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inq_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				inq_v_q <= 1'b1;
			else if (take)
				inq_v_q <= 1'b0;
			if (res_valid)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			inq_q.mode        <= mode_t'(s_tuser);
			inq_q.mem_address <= s_tdata[7:0];
			inq_q.mem_data    <= s_tdata[23:8];
		end
		if (res_valid)
			out_q <= res;
	end

	acs_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (inq_v_q),
		.item       (inq_q),
		.can_out    (can_out),
		.take       (take),
		.res_valid  (res_valid),
		.res        (res),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata)
	);

	// main memory
	acs_ram #(
		.WORDS (MEM_WORDS),
		.WIDTH (DATA_W)
	) u_mem (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule

@@ sim/acs_step_monitor.sv @@
// ---------------------------------------------------------------------------
// acs_step_monitor
// watches both stream channels of the accumulator cpu step block, runs its
// own copy of the machine on every accepted command beat and compares each
// result beat field by field with the oldest predicted one
// ---------------------------------------------------------------------------
module acs_step_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // mem_address[7:0], mem_data[23:8]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	// read_data[15:0], pc_now[23:16], cond_code[25:24], halted[26],
	// reg_written[27], reg_index[29:28], reg_value[45:30], mem_written[46],
	// store_address[54:47], zero fill[55]
	input  logic [55:0] m_tdata,
	output int          fail_count,
	output int          open_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import acs_pkg::*;

	// machine state as the block should hold it
	logic [DATA_W-1:0] words [MEM_WORDS];
	logic [DATA_W-1:0] regs [REG_COUNT];
	logic [ADDR_W-1:0] pc;
	logic [DATA_W-1:0] ir;
	logic [1:0]        cc;
	logic              halt;

	res_t step_results [$];

	function automatic logic [1:0] sign_class(input logic [DATA_W-1:0] v);
		if (v == '0)
			return CC_ZERO;
		return v[DATA_W-1] ? CC_NEG : CC_POS;
	endfunction

	function automatic res_t machine_step(input mode_t m, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d);
		res_t r;
		op_t opc;
		logic [1:0] rn;
		logic [ADDR_W-1:0] ad;
		logic [DATA_W-1:0] opd;
		logic [DATA_W-1:0] acc;
		logic [DATA_W-1:0] val;
		logic wr;
		r = '0;
		case (m)
			MODE_WRITE: words[a] = d;
			MODE_SETPC: begin
				pc = a;
				halt = 1'b0;
			end
			MODE_READ: r.read_data = words[a];
			default: if (!halt) begin
				ir = words[pc];
				r.read_data = ir;
				pc = pc + 8'd1;
				opc = op_t'(ir[15:12]);
				rn = ir[9:8];       // ir[10] does not take part
				ad = ir[7:0];
				opd = ir[11] ? {8'h00, ad} : words[ad];
				acc = regs[0];
				val = '0;
				wr = 1'b0;
				case (opc)
					OP_LOAD: begin val = opd; wr = 1'b1; end
					OP_STORE: begin
						words[ad] = regs[rn];
						r.mem_written = 1'b1;
						r.store_address = ad;
						cc = sign_class(regs[rn]);
					end
					OP_ADD: begin val = acc + opd; wr = 1'b1; end
					OP_SUB: begin val = acc - opd; wr = 1'b1; end
					OP_ADDR: begin val = acc + regs[rn]; rn = '0; wr = 1'b1; end
					OP_SUBR: begin val = acc - regs[rn]; rn = '0; wr = 1'b1; end
					OP_AND: begin val = acc & opd; wr = 1'b1; end
					OP_OR: begin val = acc | opd; wr = 1'b1; end
					OP_NOT: begin val = ~regs[rn]; wr = 1'b1; end
					OP_JMP: pc = ad;
					OP_JZ: if (cc == CC_ZERO) pc = ad;
					OP_JP: if (cc == CC_POS) pc = ad;
					OP_JN: if (cc == CC_NEG) pc = ad;
					OP_CMP: cc = sign_class(regs[rn]);
					OP_CLR: wr = 1'b1;
					default: halt = 1'b1;
				endcase
				if (wr) begin
					regs[rn] = val;
					cc = sign_class(val);
					r.reg_written = 1'b1;
					r.reg_index = rn;
					r.reg_value = val;
				end
			end
		endcase
		r.pc_now = pc;
		r.cond_code = cc;
		r.halted = halt;
		return r;
	endfunction

	task automatic cmp_field(input string nm, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", nm, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			foreach (regs[i])
				regs[i] = '0;
			foreach (words[i])
				words[i] = '0;
			pc = '0;
			ir = '0;
			cc = CC_NONE;
			halt = 1'b0;
			step_results.delete();
		end else begin
			// the result beat always belongs to an older command than a
			// command taken at the same edge
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[54:0]);
				if (step_results.size() == 0) begin
					$error("result beat with no command outstanding: %h", m_tdata);
					fail_count++;
				end else begin
					want = step_results.pop_front();
					cmp_field("read_data", want.read_data, got.read_data);
					cmp_field("pc_now", DATA_W'(want.pc_now), DATA_W'(got.pc_now));
					cmp_field("cond_code", DATA_W'(want.cond_code),
							DATA_W'(got.cond_code));
					cmp_field("halted", DATA_W'(want.halted), DATA_W'(got.halted));
					cmp_field("reg_written", DATA_W'(want.reg_written),
							DATA_W'(got.reg_written));
					cmp_field("reg_index", DATA_W'(want.reg_index),
							DATA_W'(got.reg_index));
					cmp_field("reg_value", want.reg_value, got.reg_value);
					cmp_field("mem_written", DATA_W'(want.mem_written),
							DATA_W'(got.mem_written));
					cmp_field("store_address", DATA_W'(want.store_address),
							DATA_W'(got.store_address));
				end
			end
			if (s_tvalid && s_tready)
				step_results.push_back(machine_step(mode_t'(s_tuser), s_tdata[7:0],
						s_tdata[23:8]));
		end
		open_count = step_results.size();
	end

endmodule

@@ sim/tb_accumulator_cpu_step.sv @@
// ---------------------------------------------------------------------------
// tb_accumulator_cpu_step
// fills the whole memory, runs a hand-written program through every opcode,
// then a long random mix of short programs, stray writes, reads and pc moves,
// with random gaps on the command side and random stalls on the result side
// ---------------------------------------------------------------------------
module tb_accumulator_cpu_step;
	timeunit 1ns;
	timeprecision 1ps;

	import acs_pkg::*;

	localparam int RANDOM_BEATS = 368;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;     // mem_address[7:0], mem_data[23:8]
	logic [1:0]  s_tuser = '0;     // mode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// read_data[15:0], pc_now[23:16], cond_code[25:24], halted[26],
	// reg_written[27], reg_index[29:28], reg_value[45:30], mem_written[46],
	// store_address[54:47], zero fill[55]
	logic [55:0] m_tdata;

	int fail_count;
	int open_count;
	int beats_sent = 0;
	int random_goal;
	bit no_idle = 1'b0;   // both sides run without gaps while set

	always #4 clk = ~clk;

	accumulator_cpu_step u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	acs_step_monitor u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	function automatic int pick_gap();
		return no_idle ? 0 : $urandom_range(0, 13);
	endfunction

	function automatic logic [15:0] instr(input op_t op, input bit imm,
			input logic [2:0] rg, input logic [7:0] ad);
		return {op, imm, rg, ad};
	endfunction

	// data words lean on the values that flip the condition code or wrap
	function automatic logic [15:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'h8000;
			2: return 16'hFFFF;
			3: return 16'h7FFF;
			4: return 16'h0001;
			default: return 16'($urandom);
		endcase
	endfunction

	// halt is drawn less often so that programs get further
	function automatic logic [15:0] rand_instr();
		op_t op;
		op = op_t'($urandom_range(0, 15));
		if (op == OP_HALT && $urandom_range(0, 2) != 0)
			op = op_t'($urandom_range(0, 14));
		return instr(op, 1'($urandom), 3'($urandom), 8'($urandom));
	endfunction

	// memory image after the fill: a directed program from address 0, its
	// operands at 0x80, a word at 0xff to show the pc wrap, random elsewhere
	function automatic logic [15:0] boot_word(input logic [7:0] a);
		case (a)
			8'h00: return instr(OP_LOAD, 1'b1, 3'd0, 8'hFF);   // r0 = 0x00ff
			8'h01: return instr(OP_LOAD, 1'b0, 3'd1, 8'h80);   // r1 = 0x8000, negative
			8'h02: return instr(OP_ADD, 1'b1, 3'd2, 8'h01);
			8'h03: return instr(OP_SUB, 1'b0, 3'd3, 8'h81);    // r3 = 0, zero
			8'h04: return instr(OP_ADDR, 1'b0, 3'd1, 8'h00);
			8'h05: return instr(OP_SUBR, 1'b0, 3'd0, 8'h00);   // r0 - r0
			8'h06: return instr(OP_JZ, 1'b0, 3'd0, 8'h08);     // taken
			8'h07: return instr(OP_HALT, 1'b0, 3'd0, 8'h00);
			8'h08: return instr(OP_OR, 1'b0, 3'd0, 8'h82);     // r0 = 0xffff
			8'h09: return instr(OP_ADD, 1'b1, 3'd0, 8'h01);    // wraps to 0
			8'h0A: return instr(OP_AND, 1'b1, 3'd1, 8'h00);
			8'h0B: return instr(OP_NOT, 1'b0, 3'd1, 8'h00);
			8'h0C: return instr(OP_JN, 1'b0, 3'd0, 8'h0E);     // taken
			8'h0D: return instr(OP_HALT, 1'b0, 3'd0, 8'h00);
			8'h0E: return instr(OP_STORE, 1'b0, 3'd1, 8'h84);
			8'h0F: return instr(OP_CMP, 1'b0, 3'd3, 8'h00);
			8'h10: return instr(OP_JP, 1'b0, 3'd0, 8'h30);     // not taken
			8'h11: return instr(OP_CLR, 1'b0, 3'd6, 8'h00);    // upper reg bit ignored
			8'h12: return instr(OP_LOAD, 1'b1, 3'd0, 8'h05);
			8'h13: return instr(OP_JP, 1'b0, 3'd0, 8'h15);     // taken
			8'h14: return instr(OP_HALT, 1'b0, 3'd0, 8'h00);
			8'h15: return instr(OP_JMP, 1'b0, 3'd0, 8'h17);
			8'h16: return instr(OP_HALT, 1'b0, 3'd0, 8'h00);
			8'h17: return instr(OP_HALT, 1'b1, 3'd7, 8'hFF);
			8'h80: return 16'h8000;
			8'h81: return 16'h00FF;
			8'h82: return 16'hFFFF;
			8'h84: return 16'h1234;
			8'hFF: return instr(OP_SUB, 1'b1, 3'd0, 8'h06);
			default: return $urandom_range(0, 1) ? rand_instr() : rand_word();
		endcase
	endfunction

	// one command beat: optional idle gap, then hold valid until taken
	task automatic send_beat(input mode_t m, input logic [7:0] a, input logic [15:0] d);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= m;
		s_tdata <= {d, a};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		beats_sent++;
	endtask

	// the unused fields of execute beats carry random bits
	task automatic run_instr();
		send_beat(MODE_EXEC, 8'($urandom), 16'($urandom));
	endtask

	task automatic wait_drained();
		while (open_count != 0)
			@(posedge clk);
	endtask

	// result side: a random stall before each beat, none while no_idle is set
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = pick_gap();
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int len;
		int sel;
		logic [7:0] base;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every word is written before anything may read or fetch it
		for (int i = 0; i < MEM_WORDS; i++)
			send_beat(MODE_WRITE, 8'(i), boot_word(8'(i)));

		// directed program: every opcode, taken and skipped jumps, wraps
		send_beat(MODE_SETPC, 8'h00, 16'hFFFF);
		repeat (20) run_instr();
		run_instr();                                  // halted, nothing happens
		send_beat(MODE_SETPC, 8'hFF, 16'h0000);       // clears halt
		run_instr();                                  // pc wraps to 0
		send_beat(MODE_READ, 8'h84, 16'hFFFF);        // word left by the store
		send_beat(MODE_WRITE, 8'h84, 16'hFFFF);

		// hold the sender back until the block has drained completely
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drained();

		random_goal = beats_sent + RANDOM_BEATS;
		while (beats_sent < random_goal) begin
			if ($urandom_range(0, 59) == 0)
				no_idle = !no_idle;
			if ($urandom_range(0, 39) == 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				wait_drained();
			end
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				// short program with random content, then run it and a bit past
				len = $urandom_range(2, 8);
				base = 8'($urandom);
				for (int k = 0; k < len; k++)
					send_beat(MODE_WRITE, base + 8'(k), rand_instr());
				if ($urandom_range(0, 1))
					send_beat(MODE_WRITE, 8'($urandom), rand_word());
				send_beat(MODE_SETPC, base, 16'($urandom));
				repeat (len + $urandom_range(0, 2)) run_instr();
			end else if (sel < 75) begin
				repeat ($urandom_range(1, 4)) run_instr();
			end else if (sel < 85) begin
				send_beat(MODE_WRITE, 8'($urandom),
						$urandom_range(0, 1) ? rand_instr() : rand_word());
			end else if (sel < 93) begin
				send_beat(MODE_SETPC, 8'($urandom), 16'($urandom));
			end else begin
				send_beat(MODE_READ, 8'($urandom), 16'($urandom));
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/acs_pkg.sv
design/acs_ram.sv
design/acs_core.sv
design/accumulator_cpu_step.sv
sim/acs_step_monitor.sv
sim/tb_accumulator_cpu_step.sv
